// File: src/stmax_pkg.sv
package stmax_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int LEVEL_COUNT_DEF  = 11;

  localparam int VAL_W = 32;  // table entry and result width
  localparam int POS_W = 10;  // query position width
  localparam int LEN_W = 11;  // range length width
  localparam int K_W   = 4;   // floor(log2(length)) width

  localparam logic signed [VAL_W-1:0] NO_VALUE = -32'sd1000000000;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

// File: src/sparse_table_range_max.sv
// Channel   Ports                                   Handshake
// input     in_req_type, in_load_value, in_load_last,
//           in_query_left, in_query_right           start high while busy low
// result    out_max_value, out_query_status         out_valid, one cycle, no stall
//
// A query steps through S_QRD and S_QCMP, using the table memory's two read ports and
// the shared max unit; a query that fails its checks answers without reading the table.
// The last load starts a build that runs the shared max unit once per table entry above
// level 0: each entry passes S_BCHK and S_BWR, and each level and the finish take an S_BCHK.
// Synchronous active-low reset clears the count and the built flag; the table is not
// cleared. The result appears in the cycle after its last step and cannot be held.
module sparse_table_range_max #(
  parameter int MAX_ELEMENTS = stmax_pkg::MAX_ELEMENTS_DEF,
  parameter int LEVEL_COUNT  = stmax_pkg::LEVEL_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_req_type,
  input  logic signed [stmax_pkg::VAL_W-1:0]    in_load_value,
  input  logic                                  in_load_last,
  input  logic [stmax_pkg::POS_W-1:0]           in_query_left,
  input  logic [stmax_pkg::POS_W-1:0]           in_query_right,
  output logic                                  out_valid,
  output logic signed [stmax_pkg::VAL_W-1:0]    out_max_value,
  output logic [1:0]                            out_query_status
);

  localparam int PW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int LW    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int LVW   = $clog2(LEVEL_COUNT + 1);
  localparam int AW    = LW + PW;
  localparam int DEPTH = LEVEL_COUNT * (2 ** PW);
  localparam int XW    = ((CW > LEVEL_COUNT) ? CW : LEVEL_COUNT) + 1;
  localparam int QCW   = ((CW > stmax_pkg::POS_W) ? CW : stmax_pkg::POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BCHK,
    S_BWR,
    S_QRD,
    S_QCMP
  } state_t;

  state_t                               state_r;
  logic [CW-1:0]                        count_r;
  logic                                 ready_r;
  logic [LVW-1:0]                       lvl_r;
  logic [PW-1:0]                        j_r;
  logic [AW-1:0]                        qa_r;
  logic [AW-1:0]                        qb_r;
  logic                                 out_valid_r;
  logic signed [stmax_pkg::VAL_W-1:0]   out_max_value_r;
  stmax_pkg::status_t                   out_query_status_r;

  logic                                 we;
  logic [AW-1:0]                        waddr;
  logic signed [stmax_pkg::VAL_W-1:0]   wdata;
  logic [AW-1:0]                        raddr_a;
  logic [AW-1:0]                        raddr_b;
  logic signed [stmax_pkg::VAL_W-1:0]   rdata_a;
  logic signed [stmax_pkg::VAL_W-1:0]   rdata_b;
  logic signed [stmax_pkg::VAL_W-1:0]   max_val;

  logic                                 accept;
  logic                                 is_load;
  logic [CW-1:0]                        cnt_eff;
  logic                                 full;

  logic [stmax_pkg::LEN_W-1:0]          len_w;
  logic [stmax_pkg::K_W-1:0]            k_raw;
  logic [stmax_pkg::K_W-1:0]            k_c;
  logic [stmax_pkg::LEN_W-1:0]          pos_b;
  stmax_pkg::status_t                   q_status;

  logic [XW-1:0]                        span_w;
  logic                                 fits_w;
  logic [PW-1:0]                        half_pos;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign is_load = (in_req_type == stmax_pkg::REQ_LOAD);

  // a load after a build starts a new array
  assign cnt_eff = ready_r ? '0 : count_r;
  assign full    = (cnt_eff >= CW'(MAX_ELEMENTS));

  // query checks and level selection
  assign len_w = stmax_pkg::LEN_W'(in_query_right) - stmax_pkg::LEN_W'(in_query_left)
               + stmax_pkg::LEN_W'(1);

  always_comb begin
    k_raw = '0;
    for (int i = 1; i < stmax_pkg::LEN_W; i++) begin
      if (len_w[i]) begin
        k_raw = stmax_pkg::K_W'(i);
      end
    end
  end

  assign k_c   = (int'(k_raw) > LEVEL_COUNT - 1) ? stmax_pkg::K_W'(LEVEL_COUNT - 1) : k_raw;
  assign pos_b = stmax_pkg::LEN_W'(in_query_right) + stmax_pkg::LEN_W'(1)
               - (stmax_pkg::LEN_W'(1) << k_c);

  always_comb begin
    priority if (!ready_r) begin
      q_status = stmax_pkg::ST_RANGE;
    end else if (in_query_left > in_query_right) begin
      q_status = stmax_pkg::ST_EMPTY;
    end else if (QCW'(in_query_right) >= QCW'(count_r)) begin
      q_status = stmax_pkg::ST_RANGE;
    end else begin
      q_status = stmax_pkg::ST_OK;
    end
  end

  // build walk: entry j of level lvl exists while j + 2^lvl <= count
  assign span_w   = XW'(1) << lvl_r;
  assign fits_w   = (XW'(j_r) + span_w) <= XW'(count_r);
  assign half_pos = j_r + (PW'(1) << (lvl_r - LVW'(1)));

  assign raddr_a = (state_r == S_QRD) ? qa_r : {LW'(lvl_r - LVW'(1)), j_r};
  assign raddr_b = (state_r == S_QRD) ? qb_r : {LW'(lvl_r - LVW'(1)), half_pos};

  always_comb begin
    we    = 1'b0;
    waddr = {LW'(0), PW'(cnt_eff)};
    wdata = in_load_value;
    if (accept && is_load && !full) begin
      we = 1'b1;
    end else if (state_r == S_BWR) begin
      we    = 1'b1;
      waddr = {LW'(lvl_r), j_r};
      wdata = max_val;
    end
  end

  stmax_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  stmax_max u_max (
    .a (rdata_a),
    .b (rdata_b),
    .y (max_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a rejected query answers at once, a good one after the compare step
      out_valid_r <= ((state_r == S_IDLE) && start && !is_load
                      && (q_status != stmax_pkg::ST_OK)) || (state_r == S_QCMP);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (is_load) begin
              ready_r <= 1'b0;
              count_r <= full ? cnt_eff : cnt_eff + CW'(1);
              if (in_load_last) begin
                lvl_r   <= LVW'(1);
                j_r     <= '0;
                state_r <= S_BCHK;
              end
            end else if (q_status != stmax_pkg::ST_OK) begin
              out_max_value_r    <= stmax_pkg::NO_VALUE;
              out_query_status_r <= q_status;
            end else begin
              qa_r    <= {LW'(k_c), PW'(in_query_left)};
              qb_r    <= {LW'(k_c), PW'(pos_b)};
              state_r <= S_QRD;
            end
          end
        end
        S_BCHK: begin
          if (lvl_r >= LVW'(LEVEL_COUNT)) begin
            ready_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (fits_w) begin
            state_r <= S_BWR;
          end else begin
            // advance to the next level
            lvl_r <= lvl_r + LVW'(1);
            j_r   <= '0;
          end
        end
        S_BWR: begin
          j_r     <= j_r + PW'(1);
          state_r <= S_BCHK;
        end
        S_QRD: begin
          state_r <= S_QCMP;
        end
        S_QCMP: begin
          out_max_value_r    <= max_val;
          out_query_status_r <= stmax_pkg::ST_OK;
          state_r            <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_max_value    = out_max_value_r;
  assign out_query_status = out_query_status_r;

endmodule

// File: src/stmax_mem.sv
module stmax_mem #(
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [AW-1:0]                         waddr,
  input  logic signed [stmax_pkg::VAL_W-1:0]    wdata,
  input  logic [AW-1:0]                         raddr_a,
  input  logic [AW-1:0]                         raddr_b,
  output logic signed [stmax_pkg::VAL_W-1:0]    rdata_a,
  output logic signed [stmax_pkg::VAL_W-1:0]    rdata_b
);

  logic signed [stmax_pkg::VAL_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/stmax_max.sv
module stmax_max (
  input  logic signed [stmax_pkg::VAL_W-1:0] a,
  input  logic signed [stmax_pkg::VAL_W-1:0] b,
  output logic signed [stmax_pkg::VAL_W-1:0] y
);

  assign y = (a > b) ? a : b;

endmodule

// File: verif/tb_sparse_table_range_max.sv
`timescale 1ns / 100ps

module tb_sparse_table_range_max;

  localparam int DEPTH        = stmax_pkg::MAX_ELEMENTS_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam logic signed [stmax_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [stmax_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    stmax_pkg::req_t                     req;
    logic signed [stmax_pkg::VAL_W-1:0]  value;
    logic                                last;
    logic [stmax_pkg::POS_W-1:0]         left;
    logic [stmax_pkg::POS_W-1:0]         right;
  } beat_t;

  typedef struct {
    logic signed [stmax_pkg::VAL_W-1:0]  val;
    stmax_pkg::status_t                  status;
  } answer_t;

  typedef struct {
    beat_t   b;
    bit      pinned;
    answer_t res;
  } plan_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic                               in_req_type = 1'b0;
  logic signed [stmax_pkg::VAL_W-1:0] in_load_value = '0;
  logic                               in_load_last = 1'b0;
  logic [stmax_pkg::POS_W-1:0]        in_query_left = '0;
  logic [stmax_pkg::POS_W-1:0]        in_query_right = '0;
  logic                               out_valid;
  logic signed [stmax_pkg::VAL_W-1:0] out_max_value;
  logic [1:0]                         out_query_status;

  // shadow of the loaded array
  logic signed [stmax_pkg::VAL_W-1:0] base_vals [DEPTH];
  int unsigned                        held = 0;
  bit                                 built = 1'b0;

  answer_t   answer_q [$];
  answer_t   mon_want;
  answer_t   unpinned;
  plan_row_t plan [$];
  int        fails = 0;
  int        counted = 0;

  sparse_table_range_max u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_load_value    (in_load_value),
    .in_load_last     (in_load_last),
    .in_query_left    (in_query_left),
    .in_query_right   (in_query_right),
    .out_valid        (out_valid),
    .out_max_value    (out_max_value),
    .out_query_status (out_query_status)
  );

  always #1 clk = ~clk;

  function automatic bit absorb_load(beat_t b);
    bit stored;
    stored = 1'b0;
    // a load after a build starts a new array
    if (built) begin
      built = 1'b0;
      held = 0;
    end
    if (held < DEPTH) begin
      base_vals[held] = b.value;
      held++;
      stored = 1'b1;
    end
    if (b.last) built = 1'b1;
    return stored;
  endfunction

  function automatic answer_t answer_query(beat_t b);
    answer_t     res;
    int unsigned p;
    res.val = stmax_pkg::NO_VALUE;
    res.status = stmax_pkg::ST_OK;
    if (!built) res.status = stmax_pkg::ST_RANGE;
    else if (b.left > b.right) res.status = stmax_pkg::ST_EMPTY;
    else if (b.right >= held) res.status = stmax_pkg::ST_RANGE;
    else begin
      res.val = base_vals[b.left];
      for (p = b.left + 1; p <= b.right; p++)
        if (base_vals[p] > res.val) res.val = base_vals[p];
    end
    return res;
  endfunction

  function automatic logic signed [stmax_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return int'($urandom_range(0, 16)) - 8;  // force ties
      default: return $urandom;
    endcase
  endfunction

  function automatic beat_t pick_load(bit fin);
    beat_t b;
    b.req = stmax_pkg::REQ_LOAD;
    b.value = pick_value();
    b.last = fin;
    b.left = stmax_pkg::POS_W'($urandom_range(0, 1023));
    b.right = stmax_pkg::POS_W'($urandom_range(0, 1023));
    return b;
  endfunction

  function automatic beat_t pick_query(bit legal);
    beat_t       b;
    int unsigned span;
    b.req = stmax_pkg::REQ_QUERY;
    b.value = $urandom;
    b.last = 1'($urandom_range(0, 1));
    if (legal && built && held > 0) begin
      b.left = stmax_pkg::POS_W'($urandom_range(0, held - 1));
      case ($urandom_range(0, 3))
        0: b.right = b.left;
        1: b.right = stmax_pkg::POS_W'($urandom_range(b.left, held - 1));
        2: b.right = stmax_pkg::POS_W'(held - 1);
        default: begin
          // land on and just below power-of-two lengths
          span = (1 << $urandom_range(0, 10)) - $urandom_range(0, 1);
          if (span == 0) span = 1;
          b.right = stmax_pkg::POS_W'((b.left + span - 1 < held) ? b.left + span - 1
                                                                  : held - 1);
        end
      endcase
    end else begin
      b.left = stmax_pkg::POS_W'($urandom_range(0, 1023));
      b.right = stmax_pkg::POS_W'($urandom_range(0, 1023));
    end
    return b;
  endfunction

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 11));
  endfunction

  // call at a rising edge; returns at the edge that accepts the beat
  task automatic send_beat(input beat_t b, input int gap, input bit pinned,
                           input answer_t pin_res);
    answer_t res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_req_type    <= b.req;
    in_load_value  <= b.value;
    in_load_last   <= b.last;
    in_query_left  <= b.left;
    in_query_right <= b.right;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (b.req == stmax_pkg::REQ_QUERY) begin
      res = pinned ? pin_res : answer_query(b);
      answer_q.push_back(res);
      counted++;
    end else if (absorb_load(b)) begin
      counted++;
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
  endtask

  task automatic run_well_formed(input bit quiet, input int unsigned n);
    int unsigned k;
    int unsigned nq;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 24) == 0) send_beat(pick_query(1'b0), draw_gap(quiet), 1'b0, unpinned);
      send_beat(pick_load(k == n - 1), draw_gap(quiet), 1'b0, unpinned);
    end
    nq = $urandom_range(1, 24);
    for (k = 0; k < nq; k++)
      send_beat(pick_query($urandom_range(0, 4) != 0), draw_gap(quiet), 1'b0, unpinned);
  endtask

  task automatic run_noise(input bit quiet);
    int    k;
    int    n;
    beat_t b;
    n = $urandom_range(1, 10);
    for (k = 0; k < n; k++) begin
      b.req = stmax_pkg::req_t'($urandom_range(0, 1));
      b.value = $urandom;
      b.last = ($urandom_range(0, 7) == 0);
      b.left = stmax_pkg::POS_W'($urandom_range(0, 1023));
      b.right = stmax_pkg::POS_W'($urandom_range(0, 1023));
      send_beat(b, draw_gap(quiet), 1'b0, unpinned);
    end
  endtask

  // fill the array, push past its end, and build on a dropped beat
  task automatic run_full_array(input bit quiet);
    int    k;
    beat_t b;
    for (k = 0; k < DEPTH + 4; k++)
      send_beat(pick_load(k == DEPTH + 3), draw_gap(quiet), 1'b0, unpinned);
    b = pick_query(1'b1);
    b.left = '0;
    b.right = stmax_pkg::POS_W'(DEPTH - 1);
    send_beat(b, draw_gap(quiet), 1'b0, unpinned);
    b.left = stmax_pkg::POS_W'(DEPTH - 1);
    send_beat(b, draw_gap(quiet), 1'b0, unpinned);
    b.right = '0;
    send_beat(b, draw_gap(quiet), 1'b0, unpinned);
    b.left = stmax_pkg::POS_W'(DEPTH / 2);
    b.right = stmax_pkg::POS_W'(DEPTH - 1);
    send_beat(b, draw_gap(quiet), 1'b0, unpinned);
    for (k = 0; k < 12; k++) send_beat(pick_query(1'b1), draw_gap(quiet), 1'b0, unpinned);
  endtask

  function automatic void add_load(logic signed [stmax_pkg::VAL_W-1:0] value, logic last);
    plan_row_t r;
    r.b = pick_load(last);
    r.b.value = value;
    r.pinned = 1'b0;
    r.res = unpinned;
    plan.push_back(r);
  endfunction

  function automatic void add_query(int left, int right,
                                    bit pinned, logic signed [stmax_pkg::VAL_W-1:0] val,
                                    stmax_pkg::status_t status);
    plan_row_t r;
    r.b = pick_query(1'b0);
    r.b.left = stmax_pkg::POS_W'(left);
    r.b.right = stmax_pkg::POS_W'(right);
    r.pinned = pinned;
    r.res.val = val;
    r.res.status = status;
    plan.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $error("result beat with nothing expected: max_value %0d query_status %0d",
               out_max_value, out_query_status);
        fails++;
      end else begin
        mon_want = answer_q.pop_front();
        if (out_max_value !== mon_want.val) begin
          $error("max_value: expected %0d, got %0d", mon_want.val, out_max_value);
          fails++;
        end
        if (out_query_status !== mon_want.status) begin
          $error("query_status: expected %0d, got %0d", mon_want.status, out_query_status);
          fails++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int seq;
    int kind;
    bit quiet;
    unpinned.val = stmax_pkg::NO_VALUE;
    unpinned.status = stmax_pkg::ST_OK;

    // query before any build, not-ready check wins over empty range
    add_query(0, 0, 1'b1, stmax_pkg::NO_VALUE, stmax_pkg::ST_RANGE);
    add_query(1023, 0, 1'b1, stmax_pkg::NO_VALUE, stmax_pkg::ST_RANGE);
    add_load(VAL_MAX, 1'b0);
    add_load(VAL_MIN, 1'b0);
    add_load(-5, 1'b0);
    add_query(0, 0, 1'b1, stmax_pkg::NO_VALUE, stmax_pkg::ST_RANGE);
    add_load(0, 1'b1);
    add_query(0, 3, 1'b0, 0, stmax_pkg::ST_OK);
    add_query(1, 1, 1'b1, VAL_MIN, stmax_pkg::ST_OK);
    add_query(1, 3, 1'b0, 0, stmax_pkg::ST_OK);
    add_query(2, 1, 1'b1, stmax_pkg::NO_VALUE, stmax_pkg::ST_EMPTY);
    add_query(1023, 0, 1'b1, stmax_pkg::NO_VALUE, stmax_pkg::ST_EMPTY);
    add_query(0, 4, 1'b1, stmax_pkg::NO_VALUE, stmax_pkg::ST_RANGE);
    add_query(1023, 1023, 1'b1, stmax_pkg::NO_VALUE, stmax_pkg::ST_RANGE);
    add_query(2, 2, 1'b1, -5, stmax_pkg::ST_OK);
    // load after build starts a one-entry array
    add_load(3, 1'b1);
    add_query(0, 0, 1'b1, 3, stmax_pkg::ST_OK);
    add_query(0, 1, 1'b1, stmax_pkg::NO_VALUE, stmax_pkg::ST_RANGE);
    add_load(10, 1'b0);
    add_load(10, 1'b0);
    add_load(-1, 1'b1);
    add_query(0, 2, 1'b0, 0, stmax_pkg::ST_OK);
    add_query(1, 2, 1'b0, 0, stmax_pkg::ST_OK);
    add_query(2, 2, 1'b1, -1, stmax_pkg::ST_OK);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_beat(plan[i].b, draw_gap(1'b0), plan[i].pinned, plan[i].res);

    counted = 0;
    seq = 0;
    while (counted < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (seq == 0 || $urandom_range(0, 5) == 0) drain_results();
      kind = $urandom_range(0, 99);
      if (seq == 2) run_full_array(quiet);
      else if (kind < 80)
        run_well_formed(quiet, ($urandom_range(0, 29) == 0) ? $urandom_range(41, 400)
                                                             : $urandom_range(1, 40));
      else run_noise(quiet);
      seq++;
    end

    start <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
    repeat (40) @(posedge clk);
    if (fails == 0 && answer_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/stmax_pkg.sv
src/stmax_mem.sv
src/stmax_max.sv
src/sparse_table_range_max.sv
verif/tb_sparse_table_range_max.sv
